>>> hw/rtl/start_side_line_vote_core_macros.svh
// Assertion macros shared by the start-side line vote RTL.
`ifndef START_SIDE_LINE_VOTE_CORE_MACROS_SVH
`define START_SIDE_LINE_VOTE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define SSLV_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SSLV_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SSLV_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define SSLV_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg)
`endif

`endif

>>> hw/rtl/sslv_pkg.sv
// Shared types and constants of the start-side line vote block.
package sslv_pkg;

	// Start mode codes
	localparam logic [1:0] MODE_VOTE  = 2'd0;
	localparam logic [1:0] MODE_LEFT  = 2'd1;
	localparam logic [1:0] MODE_RIGHT = 2'd2;

	// Frame vote codes
	localparam logic [1:0] VOTE_NONE  = 2'd0;
	localparam logic [1:0] VOTE_LEFT  = 2'd1;
	localparam logic [1:0] VOTE_RIGHT = 2'd2;

	// Configuration register indexes
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_START_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_COL   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MIN_ROW_SUM  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SLOPE_LIMIT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_TOT_LEN  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIN_CONF     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_REQ_FRAMES   = 3'd6;
	localparam int unsigned CFG_DATA_W = 16;

	// Result queue geometry
	localparam int unsigned OUTQ_DEPTH = 8;
	localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

	localparam int unsigned STREAK_MAX = 255;

	// Pipeline control carried between stages
	typedef struct packed {
		logic valid;
		logic last;
	} sslv_ctl_t;

	// One result item, frame_vote in the lowest bits
	typedef struct packed {
		logic [31:0] right_total;
		logic [31:0] left_total;
		logic        locked_side;
		logic        side_locked;
		logic [7:0]  vote_streak;
		logic [1:0]  frame_vote;
	} sslv_item_t;

	localparam int unsigned ITEM_W     = $bits(sslv_item_t);
	localparam int unsigned OUT_TDATA_W = ((ITEM_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/sslv_seg.sv
// Segment filter and left/right length split, one registered stage.
module sslv_seg
	import sslv_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int ADD_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sslv_ctl_t             ctl_s1,
	input  logic                  seg_s1,
	input  logic [COORD_BITS-1:0] u0_s1,
	input  logic [COORD_BITS-1:0] v0_s1,
	input  logic [COORD_BITS-1:0] u1_s1,
	input  logic [COORD_BITS-1:0] v1_s1,
	input  logic [15:0]           center_column,
	input  logic [12:0]           min_row_sum,
	input  logic [7:0]            slope_limit,
	output sslv_ctl_t             ctl_s2,
	output logic [ADD_BITS-1:0]   ladd_s2,
	output logic [ADD_BITS-1:0]   radd_s2
);

	localparam int RW = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;

	logic [COORD_BITS-1:0] lo, hi, du, dv;
	logic [COORD_BITS+7:0] dv_sh, slope_rhs;
	logic [COORD_BITS:0]   row_sum;
	logic [RW-1:0]         row_sum_x, min_row_x;
	logic [ADD_BITS-1:0]   lo16, hi16, cx, l_end, r_start, ladd, radd;
	logic                  counted;

	// Sort endpoints, measure extents and test the segment
	always_comb begin
		lo        = (u0_s1 < u1_s1) ? u0_s1 : u1_s1;
		hi        = (u0_s1 < u1_s1) ? u1_s1 : u0_s1;
		du        = hi - lo;
		dv        = (v0_s1 > v1_s1) ? v0_s1 - v1_s1 : v1_s1 - v0_s1;
		dv_sh     = {dv, 8'b0};
		slope_rhs = du * slope_limit;
		row_sum   = {1'b0, v0_s1} + {1'b0, v1_s1};
		row_sum_x = RW'(row_sum);
		min_row_x = RW'(min_row_sum);
		counted   = seg_s1 && (du != '0) && (dv_sh <= slope_rhs) && (row_sum_x >= min_row_x);
	end

	// Split the extent at the center column, in 1/16 pixel
	always_comb begin
		lo16    = ADD_BITS'({lo, 4'b0});
		hi16    = ADD_BITS'({hi, 4'b0});
		cx      = ADD_BITS'(center_column);
		l_end   = (hi16 < cx) ? hi16 : cx;
		r_start = (lo16 > cx) ? lo16 : cx;
		ladd    = (counted && (l_end > lo16)) ? l_end - lo16 : '0;
		radd    = (counted && (hi16 > r_start)) ? hi16 - r_start : '0;
	end

	// Advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		ladd_s2 <= ladd;
		radd_s2 <= radd;
	end

endmodule

>>> hw/rtl/sslv_acc.sv
// Saturating left/right frame accumulators; emits totals on frame end.
module sslv_acc
	import sslv_pkg::*;
#(
	parameter int ACC_BITS = 32,
	parameter int ADD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sslv_ctl_t           ctl_s2,
	input  logic [ADD_BITS-1:0] ladd_s2,
	input  logic [ADD_BITS-1:0] radd_s2,
	output logic                frame_s3,
	output logic [ACC_BITS-1:0] left_s3,
	output logic [ACC_BITS-1:0] right_s3
);

	logic [ACC_BITS-1:0] left_acc_q, right_acc_q;
	logic [ACC_BITS:0]   lsum, rsum;
	logic [ACC_BITS-1:0] lsat, rsat;

	// Add the stage's lengths with saturation
	always_comb begin
		lsum = (ACC_BITS + 1)'(left_acc_q) + (ACC_BITS + 1)'(ladd_s2);
		rsum = (ACC_BITS + 1)'(right_acc_q) + (ACC_BITS + 1)'(radd_s2);
		lsat = lsum[ACC_BITS] ? '1 : lsum[ACC_BITS-1:0];
		rsat = rsum[ACC_BITS] ? '1 : rsum[ACC_BITS-1:0];
	end

	// Accumulate, or drop the totals on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_acc_q  <= '0;
			right_acc_q <= '0;
			frame_s3    <= 1'b0;
		end else begin
			frame_s3 <= ctl_s2.valid && ctl_s2.last;
			if (ctl_s2.valid) begin
				if (ctl_s2.last) begin
					left_acc_q  <= '0;
					right_acc_q <= '0;
				end else begin
					left_acc_q  <= lsat;
					right_acc_q <= rsat;
				end
			end
		end
	end

	// Hold the frame totals for the decision stage
	always_ff @(posedge clk) begin
		left_s3  <= lsat;
		right_s3 <= rsat;
	end

endmodule

>>> hw/rtl/sslv_vote.sv
// Frame test, streak counting and side lock.
`include "start_side_line_vote_core_macros.svh"
module sslv_vote
	import sslv_pkg::*;
#(
	parameter int ACC_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frame_s3,
	input  logic [ACC_BITS-1:0] left_s3,
	input  logic [ACC_BITS-1:0] right_s3,
	input  logic [1:0]          start_mode,
	input  logic [15:0]         min_total_length,
	input  logic [8:0]          min_confidence,
	input  logic [7:0]          required_frames,
	output logic                frame_s4,
	output logic                push,
	output sslv_item_t          item
);

	localparam int TW = ACC_BITS + 1;
	localparam int PW = ACC_BITS + 10;

	logic [TW-1:0]       total_s4;
	logic [ACC_BITS-1:0] diff_s4;
	logic                gt_s4;
	logic [31:0]         lout_s4, rout_s4;

	logic [7:0] streak_q;
	logic [1:0] prev_vote_q;
	logic       lock_q;
	logic       lock_side_q;

	logic [TW-1:0]       total;
	logic [ACC_BITS-1:0] diff;
	logic [63:0]         lx, rx;
	logic [TW-1:0]       len16;
	logic [PW-1:0]       prod, diff_sh;
	logic                fixed, pass;
	logic [1:0]          vote_d, prev_d;
	logic [7:0]          streak_d;
	logic                lock_d, lock_side_d;

	// Form total, imbalance and the 32-bit report values
	always_comb begin
		total = TW'(left_s3) + TW'(right_s3);
		diff  = (right_s3 > left_s3) ? right_s3 - left_s3 : left_s3 - right_s3;
		lx    = 64'(left_s3);
		rx    = 64'(right_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_s4 <= 1'b0;
		end else begin
			frame_s4 <= frame_s3;
		end
	end

	always_ff @(posedge clk) begin
		total_s4 <= total;
		diff_s4  <= diff;
		gt_s4    <= right_s3 > left_s3;
		lout_s4  <= (lx[63:32] != '0) ? 32'hFFFF_FFFF : lx[31:0];
		rout_s4  <= (rx[63:32] != '0) ? 32'hFFFF_FFFF : rx[31:0];
	end

	// Length and confidence test, then the streak update
	always_comb begin
		len16   = TW'({min_total_length, 4'b0});
		prod    = total_s4 * min_confidence;
		diff_sh = {2'b0, diff_s4, 8'b0};
		pass    = (total_s4 >= len16) && (diff_sh >= prod);
		fixed   = (start_mode == MODE_LEFT) || (start_mode == MODE_RIGHT);

		vote_d      = VOTE_NONE;
		prev_d      = prev_vote_q;
		streak_d    = streak_q;
		lock_d      = lock_q;
		lock_side_d = lock_side_q;
		if (!fixed && !lock_q) begin
			if (!pass) begin
				streak_d = '0;
				prev_d   = VOTE_NONE;
			end else begin
				vote_d = gt_s4 ? VOTE_RIGHT : VOTE_LEFT;
				if (vote_d == prev_vote_q) begin
					if (streak_q != 8'(STREAK_MAX)) begin
						streak_d = streak_q + 8'd1;
					end
				end else begin
					prev_d   = vote_d;
					streak_d = 8'd1;
				end
				if (streak_d >= required_frames) begin
					lock_d      = 1'b1;
					lock_side_d = (vote_d == VOTE_RIGHT);
				end
			end
		end
	end

	// Hold vote state between frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streak_q    <= '0;
			prev_vote_q <= VOTE_NONE;
			lock_q      <= 1'b0;
			lock_side_q <= 1'b0;
		end else if (frame_s4) begin
			streak_q    <= streak_d;
			prev_vote_q <= prev_d;
			lock_q      <= lock_d;
			lock_side_q <= lock_side_d;
		end
	end

	// Build the result item for the queue
	always_comb begin
		push             = frame_s4;
		item.frame_vote  = vote_d;
		item.vote_streak = streak_d;
		item.side_locked = fixed ? 1'b1 : lock_d;
		item.locked_side = fixed ? (start_mode == MODE_RIGHT) : (lock_d && lock_side_d);
		item.left_total  = lout_s4;
		item.right_total = rout_s4;
	end

	`SSLV_ASSERT_NEXT(a_lock_sticks, clk, arst_n, lock_q, lock_q, "side lock dropped")
	`SSLV_ASSERT_NEXT(a_locked_streak_held, clk, arst_n, lock_q, $stable(streak_q), "streak moved after lock")
	`SSLV_ASSERT(a_vote_only_unlocked, clk, arst_n, !(push && (item.frame_vote != VOTE_NONE) && (fixed || lock_q)), "vote while locked or fixed")

endmodule

>>> hw/rtl/sslv_outq.sv
// Result queue that decouples the pipeline from the output stream.
`include "start_side_line_vote_core_macros.svh"
module sslv_outq
	import sslv_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sslv_item_t             item,
	output logic [OUTQ_PTR_W:0]    count,
	output logic                   tvalid,
	input  logic                   tready,
	output sslv_item_t             head
);

	sslv_item_t              mem_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [OUTQ_PTR_W:0]     count_q;
	logic                    pop;

	assign pop    = tvalid && tready;
	assign tvalid = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign count  = count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item;
		end
	end

	`SSLV_ASSERT(a_count_bound, clk, arst_n, count_q <= (OUTQ_PTR_W + 1)'(OUTQ_DEPTH), "queue overfilled")
	`SSLV_ASSERT(a_no_push_full, clk, arst_n, !(push && (count_q == (OUTQ_PTR_W + 1)'(OUTQ_DEPTH))), "push into full queue")

endmodule

>>> hw/rtl/start_side_line_vote_core.sv
// Top level of the start-side line vote: config, input stage and pipeline.
// A frame-last transfer passes the input register, segment split, accumulate, totals
// and queue registers before its result can be taken.
// Throughput: one input transfer per cycle; input stalls only while queued results
// plus frame ends still in the pipeline take all 8 result queue entries.
// Reset (arst_n low) clears totals, streak, lock, valids and queue, loads config defaults.
module start_side_line_vote_core
	import sslv_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int ACC_BITS   = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// u_start, v_start, u_end, v_end from bit 0 up, COORD_BITS each
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
	// seg_valid
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	// Result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// frame_vote[1:0], vote_streak[9:2], side_locked[10], locked_side[11],
	// left_total[43:12], right_total[75:44], zero pad above
	output logic [OUT_TDATA_W-1:0]                m_tdata,
	// Configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [REG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data
);

	localparam int ADD_BITS = (COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16;

	// Configuration registers
	logic [1:0]  start_mode_q;
	logic [15:0] center_column_q;
	logic [12:0] min_row_sum_q;
	logic [7:0]  slope_limit_q;
	logic [15:0] min_total_length_q;
	logic [8:0]  min_confidence_q;
	logic [7:0]  required_frames_q;

	sslv_ctl_t             ctl_s1, ctl_s2;
	logic                  seg_s1;
	logic [COORD_BITS-1:0] u0_s1, v0_s1, u1_s1, v1_s1;
	logic [ADD_BITS-1:0]   ladd_s2, radd_s2;
	logic                  frame_s3, frame_s4;
	logic [ACC_BITS-1:0]   left_s3, right_s3;
	logic                  push;
	sslv_item_t            item, head;
	logic [OUTQ_PTR_W:0]   q_count;
	logic [2:0]            in_flight;
	logic [OUTQ_PTR_W+1:0] reserved;
	logic                  in_xfer;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mode_q       <= MODE_VOTE;
			center_column_q    <= 16'd32768;
			min_row_sum_q      <= 13'd0;
			slope_limit_q      <= 8'd68;
			min_total_length_q <= 16'd120;
			min_confidence_q   <= 9'd90;
			required_frames_q  <= 8'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_MODE:  start_mode_q       <= cfg_data[1:0];
				REG_CENTER_COL:  center_column_q    <= cfg_data;
				REG_MIN_ROW_SUM: min_row_sum_q      <= cfg_data[12:0];
				REG_SLOPE_LIMIT: slope_limit_q      <= cfg_data[7:0];
				REG_MIN_TOT_LEN: min_total_length_q <= cfg_data;
				REG_MIN_CONF:    min_confidence_q   <= cfg_data[8:0];
				REG_REQ_FRAMES:  required_frames_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Reserve queue room for every frame end still in the pipeline
	always_comb begin
		in_flight = 3'(ctl_s1.valid && ctl_s1.last) + 3'(ctl_s2.valid && ctl_s2.last)
			+ 3'(frame_s3) + 3'(frame_s4);
		reserved  = (OUTQ_PTR_W + 2)'(q_count) + (OUTQ_PTR_W + 2)'(in_flight);
		s_tready  = reserved < (OUTQ_PTR_W + 2)'(OUTQ_DEPTH);
		in_xfer   = s_tvalid && s_tready;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= in_xfer;
			ctl_s1.last  <= in_xfer && s_tlast;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			seg_s1 <= s_tuser;
			u0_s1  <= s_tdata[COORD_BITS-1:0];
			v0_s1  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			u1_s1  <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
			v1_s1  <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
		end
	end

	sslv_seg #(
		.COORD_BITS(COORD_BITS),
		.ADD_BITS  (ADD_BITS)
	) u_seg (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.seg_s1       (seg_s1),
		.u0_s1        (u0_s1),
		.v0_s1        (v0_s1),
		.u1_s1        (u1_s1),
		.v1_s1        (v1_s1),
		.center_column(center_column_q),
		.min_row_sum  (min_row_sum_q),
		.slope_limit  (slope_limit_q),
		.ctl_s2       (ctl_s2),
		.ladd_s2      (ladd_s2),
		.radd_s2      (radd_s2)
	);

	sslv_acc #(
		.ACC_BITS(ACC_BITS),
		.ADD_BITS(ADD_BITS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s2  (ctl_s2),
		.ladd_s2 (ladd_s2),
		.radd_s2 (radd_s2),
		.frame_s3(frame_s3),
		.left_s3 (left_s3),
		.right_s3(right_s3)
	);

	sslv_vote #(
		.ACC_BITS(ACC_BITS)
	) u_vote (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_s3        (frame_s3),
		.left_s3         (left_s3),
		.right_s3        (right_s3),
		.start_mode      (start_mode_q),
		.min_total_length(min_total_length_q),
		.min_confidence  (min_confidence_q),
		.required_frames (required_frames_q),
		.frame_s4        (frame_s4),
		.push            (push),
		.item            (item)
	);

	sslv_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.item  (item),
		.count (q_count),
		.tvalid(m_tvalid),
		.tready(m_tready),
		.head  (head)
	);

	assign m_tdata = OUT_TDATA_W'(head);

endmodule

>>> sim/tb_start_side_line_vote_core.sv
// Testbench of the start-side line vote core: segment stream in, frame results checked.
`timescale 1ns / 100ps

module tb_start_side_line_vote_core;
	import sslv_pkg::*;

	localparam int COORD_BITS    = 12;
	localparam int S_TDATA_W     = ((4*COORD_BITS+7)/8)*8;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 12;
	// one long frame of full-width segments sent back to back
	localparam int LONG_SEGMENTS = 64;

	typedef struct {
		bit                  seg_valid;
		bit [COORD_BITS-1:0] u_start;
		bit [COORD_BITS-1:0] v_start;
		bit [COORD_BITS-1:0] u_end;
		bit [COORD_BITS-1:0] v_end;
		bit                  frame_last;
	} seg_item_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// u_start, v_start, u_end, v_end from bit 0 up
	logic [S_TDATA_W-1:0]   s_tdata;
	// seg_valid
	logic                   s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	// frame_vote, vote_streak, side_locked, locked_side, left_total, right_total
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [REG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Register copies of the predictor
	logic [1:0]  mode_q;
	logic [15:0] center_q;
	logic [12:0] row_min_q;
	logic [7:0]  slope_q;
	logic [15:0] min_len_q;
	logic [8:0]  min_conf_q;
	logic [7:0]  req_frames_q;

	// Vote state of the predictor
	logic [31:0] left_sum;
	logic [31:0] right_sum;
	logic [7:0]  streak;
	logic [1:0]  last_vote;
	logic        side_set;
	logic        side_right;

	seg_item_t  pending_items[$];
	sslv_item_t frame_results[$];
	seg_item_t  cur_item;
	bit         offering;
	bit         dense;
	int         burst_left;
	int         gap_left;
	int         hold_asked;
	int         hold_served;
	int         hold_left;
	logic [6:0] rx_tick;
	int         fail_count;

	start_side_line_vote_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input longint unsigned b);
		longint unsigned s;
		s = 64'(a) + b;
		return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	// Count a segment into the split totals and close the frame on its last item
	function automatic void tally_item(input seg_item_t it);
		longint unsigned u0, u1, v0, v1, lo, hi, du, dv;
		longint unsigned lo16, hi16, l_end, r_start, total, diff;
		logic [1:0] vote;
		bit fixed;
		sslv_item_t res;
		if (it.seg_valid) begin
			u0 = it.u_start;
			u1 = it.u_end;
			v0 = it.v_start;
			v1 = it.v_end;
			lo = (u0 < u1) ? u0 : u1;
			hi = (u0 < u1) ? u1 : u0;
			du = hi - lo;
			dv = (v0 > v1) ? v0 - v1 : v1 - v0;
			if (du != 0 && dv * 256 <= du * slope_q && v0 + v1 >= row_min_q) begin
				lo16 = lo << 4;
				hi16 = hi << 4;
				l_end = (hi16 < center_q) ? hi16 : 64'(center_q);
				r_start = (lo16 > center_q) ? lo16 : 64'(center_q);
				if (l_end > lo16)
					left_sum = sat_add32(left_sum, l_end - lo16);
				if (hi16 > r_start)
					right_sum = sat_add32(right_sum, hi16 - r_start);
			end
		end
		if (!it.frame_last)
			return;

		vote = VOTE_NONE;
		fixed = (mode_q == MODE_LEFT) || (mode_q == MODE_RIGHT);
		if (!fixed && !side_set) begin
			total = 64'(left_sum) + 64'(right_sum);
			diff = (right_sum > left_sum) ? 64'(right_sum - left_sum) : 64'(left_sum - right_sum);
			if (total < (64'(min_len_q) << 4) || diff * 256 < 64'(min_conf_q) * total) begin
				streak = 8'd0;
				last_vote = VOTE_NONE;
			end else begin
				vote = (right_sum > left_sum) ? VOTE_RIGHT : VOTE_LEFT;
				if (vote == last_vote) begin
					if (streak < STREAK_MAX)
						streak++;
				end else begin
					last_vote = vote;
					streak = 8'd1;
				end
				if (streak >= req_frames_q) begin
					side_set = 1'b1;
					side_right = (vote == VOTE_RIGHT);
				end
			end
		end
		res.frame_vote = vote;
		res.vote_streak = streak;
		res.side_locked = fixed | side_set;
		res.locked_side = fixed ? (mode_q == MODE_RIGHT) : (side_set & side_right);
		res.left_total = left_sum;
		res.right_total = right_sum;
		frame_results = {frame_results, res};
		left_sum = '0;
		right_sum = '0;
	endfunction

	function automatic void reset_model();
		mode_q = MODE_VOTE;
		center_q = 16'd32768;
		row_min_q = '0;
		slope_q = 8'd68;
		min_len_q = 16'd120;
		min_conf_q = 9'd90;
		req_frames_q = 8'd3;
		left_sum = '0;
		right_sum = '0;
		streak = '0;
		last_vote = VOTE_NONE;
		side_set = 1'b0;
		side_right = 1'b0;
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Build one segment: noise anywhere, or a counted one biased to a side
	function automatic seg_item_t make_seg(input logic [1:0] side, input bit good);
		seg_item_t it;
		int cpx, anchor, other, span, du, dv, base, low_base;
		it.seg_valid = 1'b1;
		it.frame_last = 1'b0;
		it.u_start = COORD_BITS'($urandom_range(0, COORD_MAX));
		it.v_start = COORD_BITS'($urandom_range(0, COORD_MAX));
		it.u_end = COORD_BITS'($urandom_range(0, COORD_MAX));
		it.v_end = COORD_BITS'($urandom_range(0, COORD_MAX));
		if (!good) begin
			if ($urandom_range(0, 3) == 0)
				it.u_end = it.u_start;
			return it;
		end
		cpx = center_q >> 4;
		span = ($urandom_range(0, 7) == 0) ? $urandom_range(1, COORD_MAX) : $urandom_range(1, 400);
		case (side)
			VOTE_LEFT:  anchor = $urandom_range(0, cpx);
			VOTE_RIGHT: anchor = $urandom_range(cpx, COORD_MAX);
			default:    anchor = $urandom_range(0, COORD_MAX);
		endcase
		other = $urandom_range(0, 1) ? anchor + span : anchor - span;
		if (other > COORD_MAX)
			other = COORD_MAX;
		if (other < 0)
			other = 0;
		if (other == anchor)
			other = (anchor == 0) ? 1 : anchor - 1;
		du = (other > anchor) ? other - anchor : anchor - other;
		// keep the slope and the midpoint row admissible
		dv = $urandom_range(0, du * slope_q / 256);
		low_base = (row_min_q + 1) / 2;
		if (low_base > COORD_MAX - dv)
			low_base = COORD_MAX - dv;
		base = $urandom_range(low_base, COORD_MAX - dv);
		if ($urandom_range(0, 1)) begin
			it.u_start = COORD_BITS'(anchor);
			it.u_end = COORD_BITS'(other);
		end else begin
			it.u_start = COORD_BITS'(other);
			it.u_end = COORD_BITS'(anchor);
		end
		if ($urandom_range(0, 1)) begin
			it.v_start = COORD_BITS'(base);
			it.v_end = COORD_BITS'(base + dv);
		end else begin
			it.v_start = COORD_BITS'(base + dv);
			it.v_end = COORD_BITS'(base);
		end
		return it;
	endfunction

	task automatic push_seg(input bit seg, input int u0, input int v0, input int u1,
			input int v1, input bit last);
		seg_item_t it;
		it.seg_valid = seg;
		it.u_start = COORD_BITS'(u0);
		it.v_start = COORD_BITS'(v0);
		it.u_end = COORD_BITS'(u1);
		it.v_end = COORD_BITS'(v1);
		it.frame_last = last;
		pending_items = {pending_items, it};
	endtask

	// Queue random frames; a steady run keeps one side to build a streak
	task automatic queue_frames(input int n_items, input int max_segs, input bit steady);
		int made, nseg, pick;
		bit close_on_seg;
		logic [1:0] side;
		seg_item_t it;
		made = 0;
		side = $urandom_range(0, 1) ? VOTE_RIGHT : VOTE_LEFT;
		while (made < n_items) begin
			if (!steady && $urandom_range(0, 4) == 0) begin
				pick = $urandom_range(0, 2);
				side = (pick == 0) ? VOTE_NONE : (pick == 1) ? VOTE_LEFT : VOTE_RIGHT;
			end
			nseg = $urandom_range(steady ? 2 : 0, max_segs);
			close_on_seg = (nseg != 0) && ($urandom_range(0, 2) != 0);
			for (int k = 0; k < nseg; k++) begin
				it = make_seg(side, $urandom_range(0, 9) != 0);
				if ($urandom_range(0, 19) == 0)
					it.seg_valid = 1'b0;
				it.frame_last = close_on_seg && (k == nseg - 1);
				pending_items = {pending_items, it};
				made++;
			end
			// close with an empty marker that carries random coordinates
			if (!close_on_seg) begin
				it = make_seg(side, 1'b0);
				it.seg_valid = 1'b0;
				it.frame_last = 1'b1;
				pending_items = {pending_items, it};
				made++;
			end
		end
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_START_MODE:  mode_q = value[1:0];
			REG_CENTER_COL:  center_q = value[15:0];
			REG_MIN_ROW_SUM: row_min_q = value[12:0];
			REG_SLOPE_LIMIT: slope_q = value[7:0];
			REG_MIN_TOT_LEN: min_len_q = value[15:0];
			REG_MIN_CONF:    min_conf_q = value[8:0];
			REG_REQ_FRAMES:  req_frames_q = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [1:0] mode, input int unsigned center,
			input int unsigned row_min, input int unsigned slope, input int unsigned min_len,
			input int unsigned min_conf);
		write_reg(REG_START_MODE, mode);
		write_reg(REG_CENTER_COL, center);
		write_reg(REG_MIN_ROW_SUM, row_min);
		write_reg(REG_SLOPE_LIMIT, slope);
		write_reg(REG_MIN_TOT_LEN, min_len);
		write_reg(REG_MIN_CONF, min_conf);
	endtask

	// Hold off until all items went in and all frame results came back
	task automatic drain();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || offering || frame_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Feed the input stream from the pending queue in bursts with gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_tlast <= 1'b0;
			offering = 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				tally_item(cur_item);
				offering = 1'b0;
			end
			if (!offering && pending_items.size() != 0) begin
				if (gap_left != 0 && !dense) begin
					gap_left--;
				end else begin
					cur_item = pending_items.pop_front();
					offering = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			s_tvalid <= offering;
			s_tdata <= {cur_item.v_end, cur_item.u_end, cur_item.v_start, cur_item.u_start};
			s_tuser <= cur_item.seg_valid;
			s_tlast <= cur_item.frame_last;
		end
	end

	// Stall the result stream: long holds on request, else random stalls and open stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_tick <= '0;
			hold_served <= 0;
			hold_left <= 0;
		end else begin
			rx_tick <= rx_tick + 7'd1;
			if (hold_served != hold_asked) begin
				hold_served <= hold_asked;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (rx_tick[6]) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	// Compare each result transfer with the oldest predicted frame result
	always @(posedge clk) begin : result_check
		sslv_item_t got;
		sslv_item_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = sslv_item_t'(m_tdata[ITEM_W-1:0]);
			if (frame_results.size() == 0) begin
				$error("result transfer with no frame end pending");
				fail_count++;
			end else begin
				want = frame_results.pop_front();
				check_field("frame_vote", want.frame_vote, got.frame_vote);
				check_field("vote_streak", want.vote_streak, got.vote_streak);
				check_field("side_locked", want.side_locked, got.side_locked);
				check_field("locked_side", want.locked_side, got.locked_side);
				check_field("left_total", want.left_total, got.left_total);
				check_field("right_total", want.right_total, got.right_total);
			end
		end
	end

	initial begin
		#200_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int pick;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		dense = 1'b0;
		hold_asked = 0;
		fail_count = 0;
		reset_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames on reset defaults
		push_seg(1, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		push_seg(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
		push_seg(1, 100, 0, 100, COORD_MAX, 0);
		push_seg(1, 0, 0, 100, COORD_MAX, 1);
		push_seg(0, 0, 0, 0, 0, 1);
		push_seg(1, 0, 3000, 2000, 3010, 1);
		push_seg(1, COORD_MAX, 1000, 2100, 1005, 1);
		// segment starting on the split column, then one at the slope limit
		push_seg(1, 2048, 500, COORD_MAX, 500, 0);
		push_seg(1, 256, 600, 0, 668, 1);
		// just past the slope limit: frame ends empty
		push_seg(1, 0, 600, 256, 669, 1);
		drain();

		// Empty frames vote left once both thresholds are zero
		write_reg(REG_REQ_FRAMES, 255);
		write_reg(REG_MIN_TOT_LEN, 0);
		write_reg(REG_MIN_CONF, 0);
		write_reg(REG_MIN_ROW_SUM, 100);
		write_reg(REG_UNUSED, 16'hFFFF);
		push_seg(0, 0, 0, 0, 0, 1);
		push_seg(1, 10, 50, 500, 50, 1);
		push_seg(1, 10, 49, 500, 50, 1);
		push_seg(1, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1);
		drain();
		write_reg(REG_CENTER_COL, 0);
		push_seg(1, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1);
		drain();
		write_reg(REG_CENTER_COL, 16'hFFFF);
		push_seg(1, COORD_MAX, COORD_MAX, 0, COORD_MAX, 1);
		drain();

		// Short frames under a long receiver hold to fill the result queue
		set_config(MODE_VOTE, 32768, 0, 68, 120, 90);
		hold_asked++;
		queue_frames(120, 1, 1'b0);
		drain();

		// Everything admitted, spare mode code votes
		set_config(MODE_SPARE, 0, 0, 255, 0, 0);
		queue_frames(150, 8, 1'b0);
		drain();

		// Nothing admitted, strictest thresholds
		set_config(MODE_VOTE, 16'hFFFF, 8191, 0, 16'hFFFF, 256);
		queue_frames(60, 8, 1'b0);
		drain();

		repeat (3) begin
			set_config($urandom_range(0, 1) ? MODE_VOTE : MODE_SPARE, $urandom_range(0, 16'hFFFF),
				$urandom_range(0, 6000), $urandom_range(0, 255), $urandom_range(0, 400),
				$urandom_range(0, 256));
			queue_frames(100, 10, 1'b0);
			drain();
		end

		// Fixed sides report without voting
		set_config(MODE_LEFT, $urandom_range(0, 16'hFFFF), $urandom_range(0, 4000),
			$urandom_range(0, 255), $urandom_range(0, 200), $urandom_range(0, 256));
		queue_frames(80, 8, 1'b0);
		drain();
		set_config(MODE_RIGHT, $urandom_range(0, 16'hFFFF), $urandom_range(0, 4000),
			$urandom_range(0, 255), $urandom_range(0, 200), $urandom_range(0, 256));
		queue_frames(80, 8, 1'b0);
		drain();

		// One long frame of wide segments with no gaps
		set_config(MODE_VOTE, 32768, 0, 68, $urandom_range(0, 16'hFFFF), $urandom_range(0, 256));
		dense = 1'b1;
		for (int k = 0; k < LONG_SEGMENTS; k++)
			push_seg(1, 0, COORD_MAX, COORD_MAX, COORD_MAX, k == LONG_SEGMENTS - 1);
		drain();
		dense = 1'b0;

		// Steady votes until the side locks
		pick = $urandom_range(0, 2);
		write_reg(REG_REQ_FRAMES, (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 8));
		set_config(MODE_VOTE, $urandom_range(16000, 50000), 0, 128, 10, 40);
		queue_frames(200, 6, 1'b1);
		drain();

		// Locked: voting stays off in every mode
		set_config(MODE_VOTE, $urandom_range(0, 16'hFFFF), 0, $urandom_range(0, 255),
			$urandom_range(0, 200), $urandom_range(0, 256));
		queue_frames(80, 8, 1'b0);
		drain();
		write_reg(REG_START_MODE, MODE_LEFT);
		queue_frames(50, 8, 1'b0);
		drain();
		write_reg(REG_START_MODE, MODE_RIGHT);
		queue_frames(50, 8, 1'b0);
		drain();
		write_reg(REG_START_MODE, MODE_SPARE);
		queue_frames(50, 8, 1'b0);
		drain();

		if (fail_count == 0 && frame_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
